FILE: hdl/bkds_pkg.sv
package bkds_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 256;
  localparam int unsigned VALUE_BITS_DEF  = 32;
  localparam int unsigned CAP_BITS        = 9;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 9'd256;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SRCH_CMP,
    ST_DUP_RD,
    ST_DUP_CMP,
    ST_SHIFT,
    ST_SHIFT_WR,
    ST_INS,
    ST_LAST_RD,
    ST_LAST_CMP,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic rd_mid;
    logic step;
    logic rd_pos;
    logic shift_init;
    logic shift_rd;
    logic shift_wr;
    logic ins_wr;
    logic rd_last;
    logic cap_last;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic reject;
    logic srch_done;
    logic dup;
    logic at_pos;
    logic out_free;
  } status_t;

endpackage

FILE: hdl/bkds_in_if.sv
interface bkds_in_if #(parameter int unsigned VALUE_BITS = 32);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value_in;

  modport source (output valid, output value_in, input ready);
  modport sink   (input valid, input value_in, output ready);
endinterface

FILE: hdl/bkds_out_if.sv
interface bkds_out_if #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned CNT_BITS   = 9
);
  logic                  valid;
  logic                  ready;
  logic                  accepted;
  logic                  evicted_valid;
  logic [VALUE_BITS-1:0] evicted_value;
  logic [CNT_BITS-1:0]   set_count;
  logic [VALUE_BITS-1:0] set_largest;

  modport source (output valid, output accepted, output evicted_valid, output evicted_value,
                  output set_count, output set_largest, input ready);
  modport sink   (input valid, input accepted, input evicted_valid, input evicted_value,
                  input set_count, input set_largest, output ready);
endinterface

FILE: hdl/bottom_k_distinct_set_unit.sv
// Bottom-k distinct value set: keeps the k smallest distinct hash values seen.
// Input channel in_s carries one 32-bit hash value per word; output channel
// out_m returns one result word per input: accepted, evicted_valid,
// evicted_value, set_count and set_largest. The capacity register k is
// written through cfg_we / cfg_data; the user must write it only while the
// block is idle, as the block itself does not enforce this. Zero acts as
// one and values above MAX_ENTRIES saturate. Items are handled one at a
// time. A value that is rejected because the set is full and it is not
// below the largest skips the search and goes straight to the result.
// Otherwise a binary search probes the store with at most ceil(log2(count+1))
// probes, then reads the entry at the found position for the duplicate
// check; a duplicate goes straight to the result. The insert then shifts
// the entries above its position up one at a time (a read then a write on
// the store), writes the new value and reads back the new largest. The
// result is then loaded into the output register.
// A finished result sits in an output register; the next input is taken
// while it waits. If the receiver stalls, the block holds the following
// result until the register frees up and accepts nothing more meanwhile.
// Reset empties the set (count and largest to zero) and sets the capacity
// to 256; the store itself needs no clearing since only held entries are read.
module bottom_k_distinct_set_unit import bkds_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF,
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  bkds_in_if.sink             in_s,
  bkds_out_if.source          out_m,
  input  logic                cfg_we,
  input  logic [CAP_BITS-1:0] cfg_data
);
  cmd_t    cmd;
  status_t status;

  // The controller sequences search, duplicate check, shift and insert.
  bkds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_s.valid),
    .in_ready (in_s.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath owns the sorted store, the count, the largest value and the
  // output register.
  bkds_dp #(.MAX_ENTRIES(MAX_ENTRIES), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .value_in          (in_s.value_in),
    .cfg_we            (cfg_we),
    .cfg_data          (cfg_data),
    .out_valid         (out_m.valid),
    .out_ready         (out_m.ready),
    .out_accepted      (out_m.accepted),
    .out_evicted_valid (out_m.evicted_valid),
    .out_evicted_value (out_m.evicted_value),
    .out_set_count     (out_m.set_count),
    .out_set_largest   (out_m.set_largest)
  );
endmodule

FILE: hdl/bkds_ram.sv
module bkds_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/bkds_ctrl.sv
module bkds_ctrl import bkds_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_SRCH;
      ST_SRCH: begin
        if (status.reject)         state_nxt = ST_DONE;
        else if (status.srch_done) state_nxt = ST_DUP_RD;
        else                       state_nxt = ST_SRCH_CMP;
      end
      ST_SRCH_CMP: state_nxt = ST_SRCH;
      ST_DUP_RD:   state_nxt = ST_DUP_CMP;
      ST_DUP_CMP:  state_nxt = status.dup ? ST_DONE : ST_SHIFT;
      ST_SHIFT:    state_nxt = status.at_pos ? ST_INS : ST_SHIFT_WR;
      ST_SHIFT_WR: state_nxt = ST_SHIFT;
      ST_INS:      state_nxt = ST_LAST_RD;
      ST_LAST_RD:  state_nxt = ST_LAST_CMP;
      ST_LAST_CMP: state_nxt = ST_DONE;
      ST_DONE:     if (status.out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SRCH:     cmd.rd_mid = !status.reject && !status.srch_done;
      ST_SRCH_CMP: cmd.step = 1'b1;
      ST_DUP_RD:   cmd.rd_pos = 1'b1;
      ST_DUP_CMP:  cmd.shift_init = 1'b1;
      ST_SHIFT:    cmd.shift_rd = !status.at_pos;
      ST_SHIFT_WR: cmd.shift_wr = 1'b1;
      ST_INS:      cmd.ins_wr = 1'b1;
      ST_LAST_RD:  cmd.rd_last = 1'b1;
      ST_LAST_CMP: cmd.cap_last = 1'b1;
      ST_DONE:     cmd.out_load = status.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end
endmodule

FILE: hdl/bkds_dp.sv
module bkds_dp import bkds_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF,
  localparam int unsigned AW = $clog2(MAX_ENTRIES),
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1),
  localparam int unsigned EW = (CW > CAP_BITS) ? CW : CAP_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic [VALUE_BITS-1:0] value_in,
  input  logic                  cfg_we,
  input  logic [CAP_BITS-1:0]   cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_accepted,
  output logic                  out_evicted_valid,
  output logic [VALUE_BITS-1:0] out_evicted_value,
  output logic [CW-1:0]         out_set_count,
  output logic [VALUE_BITS-1:0] out_set_largest
);
  localparam logic [EW-1:0] MAX_E = EW'(MAX_ENTRIES);
  localparam logic [EW-1:0] ONE_E = EW'(1);

  logic [CAP_BITS-1:0]   cap_r;
  logic [CW-1:0]         count_r;
  logic [VALUE_BITS-1:0] largest_r;
  logic [VALUE_BITS-1:0] value_r;
  logic [CW-1:0]         lo_r, hi_r, mid_r, idx_r;
  logic                  acc_r, ev_r;
  logic [VALUE_BITS-1:0] evval_r;
  logic                  ov_r, oacc_r, oev_r;
  logic [VALUE_BITS-1:0] oevval_r, olarg_r;
  logic [CW-1:0]         ocnt_r;

  logic [EW-1:0]         cap_x, cap_eff;
  logic                  full;
  logic [CW-1:0]         mid;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [VALUE_BITS-1:0] ram_wdata, ram_rdata;
  logic [CW-1:0]         idx_m1, count_m1;

  bkds_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Capacity zero acts as one, and anything above the store depth saturates.
  assign cap_x   = EW'(cap_r);
  assign cap_eff = (cap_x == '0) ? ONE_E : ((cap_x > MAX_E) ? MAX_E : cap_x);
  assign full    = EW'(count_r) >= cap_eff;
  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign idx_m1  = idx_r - CW'(1);
  assign count_m1 = count_r - CW'(1);

  assign status.reject    = full && (value_r >= largest_r);
  assign status.srch_done = (lo_r == hi_r);
  assign status.dup       = (lo_r < count_r) && (ram_rdata == value_r);
  assign status.at_pos    = (idx_r == lo_r);
  assign status.out_free  = !ov_r || out_ready;

  always_comb begin
    ram_raddr = mid[AW-1:0];
    if (cmd.rd_pos)   ram_raddr = lo_r[AW-1:0];
    if (cmd.shift_rd) ram_raddr = idx_m1[AW-1:0];
    if (cmd.rd_last)  ram_raddr = count_m1[AW-1:0];
  end

  assign ram_we    = cmd.shift_wr || cmd.ins_wr;
  assign ram_waddr = cmd.ins_wr ? lo_r[AW-1:0] : idx_r[AW-1:0];
  assign ram_wdata = cmd.ins_wr ? value_r : ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= CAP_RESET;
      count_r   <= '0;
      largest_r <= '0;
      ov_r      <= 1'b0;
    end else begin
      if (cfg_we) cap_r <= cfg_data;
      if (cmd.ins_wr && !full) count_r <= count_r + CW'(1);
      if (cmd.cap_last) largest_r <= ram_rdata;
      if (cmd.out_load) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= value_in;
      lo_r    <= '0;
      hi_r    <= count_r;
      acc_r   <= 1'b0;
      ev_r    <= 1'b0;
      evval_r <= '0;
    end
    if (cmd.rd_mid) mid_r <= mid;
    if (cmd.step) begin
      if (ram_rdata < value_r) lo_r <= mid_r + CW'(1);
      else                     hi_r <= mid_r;
    end
    // When full the last entry drops off, so the shift starts one lower.
    if (cmd.shift_init) idx_r <= full ? count_m1 : count_r;
    if (cmd.shift_wr)   idx_r <= idx_m1;
    if (cmd.ins_wr) begin
      acc_r   <= 1'b1;
      ev_r    <= full;
      evval_r <= full ? largest_r : '0;
    end
    if (cmd.out_load) begin
      oacc_r   <= acc_r;
      oev_r    <= ev_r;
      oevval_r <= evval_r;
      ocnt_r   <= count_r;
      olarg_r  <= largest_r;
    end
  end

  assign out_valid         = ov_r;
  assign out_accepted      = oacc_r;
  assign out_evicted_valid = oev_r;
  assign out_evicted_value = oevval_r;
  assign out_set_count     = ocnt_r;
  assign out_set_largest   = olarg_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ENTRIES))
    else $error("entry count beyond store depth");

  a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_wr && !full |=> count_r == $past(count_r) + CW'(1))
    else $error("insert into a non-full set did not grow the count");

  a_evict_acc: assert property (@(posedge clk) disable iff (!rst_n)
    ev_r |-> acc_r)
    else $error("eviction without acceptance");

  a_step_order: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |=> lo_r <= hi_r)
    else $error("search bounds crossed");
endmodule

FILE: sim/tb_kmv_scoreboard.sv
`timescale 1ns / 100ps

// Scoreboard for the bottom-k set: keeps its own sorted copy of the set and
// a queue of the result words it predicts, and checks what the block returns.
class kmv_scoreboard;
  typedef struct packed {
    logic        accepted;
    logic        evicted_valid;
    logic [31:0] evicted_value;
    logic [8:0]  set_count;
    logic [31:0] set_largest;
  } kmv_result_t;

  logic [31:0]  held[$];
  int unsigned  cap_reg;
  kmv_result_t  pending[$];
  int unsigned  mismatches;

  function new();
    cap_reg = 256;
    mismatches = 0;
  endfunction

  function void set_capacity(logic [8:0] c);
    cap_reg = c;
  endfunction

  // Predicts the result word for one accepted value.
  function void note_value(logic [31:0] v);
    kmv_result_t r;
    int unsigned k;
    int pos;
    bit dup;
    k = (cap_reg == 0) ? 1 : (cap_reg > 256 ? 256 : cap_reg);
    r = '0;
    pos = held.size();
    dup = 1'b0;
    foreach (held[i]) begin
      if (held[i] >= v) begin
        pos = i;
        dup = (held[i] == v);
        break;
      end
    end
    if (held.size() < k) begin
      if (!dup) begin
        held.insert(pos, v);
        r.accepted = 1'b1;
      end
    end else if (held.size() > 0 && v < held[held.size()-1] && !dup) begin
      r.evicted_valid = 1'b1;
      r.evicted_value = held.pop_back();
      held.insert(pos, v);
      r.accepted = 1'b1;
    end
    r.set_count = 9'(held.size());
    r.set_largest = held.size() > 0 ? held[held.size()-1] : 32'd0;
    pending.push_back(r);
  endfunction

  function void check_result(kmv_result_t got);
    kmv_result_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result word %h", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected acc=%0d ev=%0d/%h cnt=%0d lg=%h, got acc=%0d ev=%0d/%h cnt=%0d lg=%h",
                 want.accepted, want.evicted_valid, want.evicted_value, want.set_count,
                 want.set_largest, got.accepted, got.evicted_valid, got.evicted_value,
                 got.set_count, got.set_largest);
    end
  endfunction
endclass

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import bkds_pkg::*;

  localparam int unsigned IDLE_LIMIT = 20000;
  // Longer than the worst item and the long receiver hold-off together;
  // a quiet spell this long is a hang.

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CAP_BITS-1:0] cfg_data = '0;

  bkds_in_if  #(.VALUE_BITS(32)) in_ch ();
  bkds_out_if #(.VALUE_BITS(32), .CNT_BITS(9)) out_ch ();

  bottom_k_distinct_set_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_s(in_ch.sink), .out_m(out_ch.source),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  kmv_scoreboard sb = new();

  // The sender's idle rate: 32 in a hundred normally, zero in a full-speed stretch.
  int unsigned send_idle_pct = 32;
  int unsigned recv_idle_pct = 32;
  bit recv_hold = 0;       // set to make the receiver hold off for a long time
  int unsigned idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.value_in = '0;
    out_ch.ready = 1'b0;
  end

  // Sample both handshakes at the rising edge; the scoreboard sees the word
  // accepted by the block before its result comes back.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_value(in_ch.value_in);
      if (out_ch.valid && out_ch.ready)
        sb.check_result({out_ch.accepted, out_ch.evicted_valid, out_ch.evicted_value,
                         out_ch.set_count, out_ch.set_largest});
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // Receiver: drives ready at the falling edge, with random idling and,
  // on request, one long hold-off counted here.
  initial begin : receiver
    int unsigned n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (recv_hold) begin
        out_ch.ready <= 1'b0;
        for (n = 0; n < 3000; n++) @(negedge clk);
        recv_hold = 0;
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one word and waits for it to be taken; idle gaps are inserted
  // before raising valid so valid stays high between back-to-back words.
  task automatic send_word(logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value_in <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Waits until every predicted result has come and the block is quiet.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic write_capacity(logic [8:0] c);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= c;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_capacity(c);
  endtask

  // Values drawn mostly from a small pool so duplicates and evictions are
  // frequent, sometimes across the whole range.
  function automatic logic [31:0] pick_value(int unsigned pool);
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(3);
      2: return $urandom_range(3);
      default: return $urandom_range(pool);
    endcase
  endfunction

  task automatic random_phase(int unsigned count, int unsigned pool);
    for (int unsigned i = 0; i < count; i++) send_word(pick_value(pool));
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset capacity of 256, extremes, duplicates.
    send_word(32'd0);
    send_word(32'hFFFF_FFFF);
    send_word(32'd0);
    send_word(32'hFFFF_FFFF);
    send_word(32'h5555_5555);
    send_word(32'hAAAA_AAAA);
    // Capacity zero behaves like one: evict when a smaller value arrives,
    // reject values at or above the largest. Count stays above capacity.
    write_capacity(9'd0);
    send_word(32'hFFFF_FFFE);
    send_word(32'h0000_0001);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    // Capacity above the store size saturates.
    write_capacity(9'd511);
    send_word(32'h8000_0000);
    send_word(32'h7FFF_FFFF);
    // A small capacity lowered below the count keeps the count.
    write_capacity(9'd1);
    send_word(32'h0000_0002);
    send_word(32'h0000_0002);
    send_word(32'h0000_0000);
    write_capacity(9'd3);
    send_word(32'h1234_5678);

    // Random phases at several capacities, small sets mostly.
    write_capacity(9'd4);
    random_phase(200, 40);
    write_capacity(9'd16);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(150, 200);
    send_idle_pct = 32; recv_idle_pct = 32;
    // Long receiver hold-off while the sender keeps offering words.
    recv_hold = 1;
    random_phase(100, 200);
    write_capacity(9'd256);
    random_phase(300, 100000);
    write_capacity(9'd2);
    random_phase(200, 20);
    write_capacity(9'd8);
    random_phase(150, 60);
    write_capacity(9'd1);
    random_phase(100, 10);
    drain();
    random_phase(100, 50);

    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule

FILE: files.f
hdl/bkds_pkg.sv
hdl/bkds_in_if.sv
hdl/bkds_out_if.sv
hdl/bkds_ram.sv
hdl/bkds_ctrl.sv
hdl/bkds_dp.sv
hdl/bottom_k_distinct_set_unit.sv
sim/tb_kmv_scoreboard.sv
sim/tb_top.sv
